### rtl/mhs_pkg.sv
package mhs_pkg;

    localparam int VAL_W     = 24;
    localparam int MASK_W    = 17;
    localparam int COEF_W    = 32;
    localparam int CHALF_W   = COEF_W / 2;
    localparam int RESP_W    = 32;
    localparam int REG_IDX_W = 1;
    localparam int N_CORNER  = 4;
    localparam int N_EDGE    = 4;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_COEF_ONE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_TWO = 1'b1;

    localparam logic signed [RESP_W-1:0] RESP_MAX = {1'b0, {(RESP_W-1){1'b1}}};
    localparam logic signed [RESP_W-1:0] RESP_MIN = {1'b1, {(RESP_W-1){1'b0}}};

    // corner order nw, ne, sw, se; edge order n, w, e, s
    // each edge is weighted by the two corner elements that share it
    localparam logic [1:0] EDGE_MASK_A [N_EDGE] = '{2'd0, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] EDGE_MASK_B [N_EDGE] = '{2'd1, 2'd2, 2'd3, 2'd3};

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [MASK_W-1:0]       mask_t;
    typedef logic [COEF_W-1:0]       coef_t;

    // corner weight width: holds m and one - m (which can go negative)
    function automatic int wt_w(int f);
        return ((f > MASK_W) ? f : MASK_W) + 2;
    endfunction

    // edge weight width: holds ma + mb and two - ma - mb
    function automatic int ew_w(int f);
        return wt_w(f) + 1;
    endfunction

    function automatic int cp_w(int f);
        return VAL_W + wt_w(f);
    endfunction

    function automatic int ep_w(int f);
        return VAL_W + ew_w(f);
    endfunction

    // eight terms, each below 2^(ep_w-1) in magnitude
    function automatic int sum_w(int f);
        return ep_w(f) + 3;
    endfunction

    function automatic int v_w(int f);
        return sum_w(f) - f;
    endfunction

endpackage

### rtl/mhs_weight.sv
module mhs_weight #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_vld,
    input  mhs_pkg::val_t                              corner_u [mhs_pkg::N_CORNER],
    input  mhs_pkg::val_t                              edge_u   [mhs_pkg::N_EDGE],
    input  mhs_pkg::mask_t                             mask     [mhs_pkg::N_CORNER],
    output logic                                       out_vld,
    output mhs_pkg::val_t                              corner_q [mhs_pkg::N_CORNER],
    output mhs_pkg::val_t                              edge_q   [mhs_pkg::N_EDGE],
    output logic signed [mhs_pkg::wt_w(FRAC_BITS)-1:0] w1c      [mhs_pkg::N_CORNER],
    output logic signed [mhs_pkg::wt_w(FRAC_BITS)-1:0] w2c      [mhs_pkg::N_CORNER],
    output logic signed [mhs_pkg::ew_w(FRAC_BITS)-1:0] w1e      [mhs_pkg::N_EDGE],
    output logic signed [mhs_pkg::ew_w(FRAC_BITS)-1:0] w2e      [mhs_pkg::N_EDGE]
);

    localparam int WT_W = mhs_pkg::wt_w(FRAC_BITS);
    localparam int EW_W = mhs_pkg::ew_w(FRAC_BITS);

    localparam logic [WT_W-1:0] ONE_C = WT_W'(1) << FRAC_BITS;
    localparam logic [EW_W-1:0] TWO_E = EW_W'(1) << (FRAC_BITS + 1);

    logic                    vld_reg;
    mhs_pkg::val_t           corner_reg [mhs_pkg::N_CORNER];
    mhs_pkg::val_t           edge_reg   [mhs_pkg::N_EDGE];
    logic signed [WT_W-1:0]  w1c_reg    [mhs_pkg::N_CORNER];
    logic signed [WT_W-1:0]  w2c_reg    [mhs_pkg::N_CORNER];
    logic signed [EW_W-1:0]  w1e_reg    [mhs_pkg::N_EDGE];
    logic signed [EW_W-1:0]  w2e_reg    [mhs_pkg::N_EDGE];
    logic signed [WT_W-1:0]  w1c_next   [mhs_pkg::N_CORNER];
    logic signed [WT_W-1:0]  w2c_next   [mhs_pkg::N_CORNER];
    logic signed [EW_W-1:0]  w1e_next   [mhs_pkg::N_EDGE];
    logic signed [EW_W-1:0]  w2e_next   [mhs_pkg::N_EDGE];
    logic [EW_W-1:0]         pair_sum   [mhs_pkg::N_EDGE];

    always_comb
    begin
        for (int i = 0; i < mhs_pkg::N_CORNER; i++)
        begin
            w1c_next[i] = WT_W'(mask[i]);
            w2c_next[i] = ONE_C - WT_W'(mask[i]);
        end
        for (int i = 0; i < mhs_pkg::N_EDGE; i++)
        begin
            pair_sum[i] = EW_W'(mask[mhs_pkg::EDGE_MASK_A[i]])
                        + EW_W'(mask[mhs_pkg::EDGE_MASK_B[i]]);
            w1e_next[i] = pair_sum[i];
            w2e_next[i] = TWO_E - pair_sum[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        corner_reg <= corner_u;
        edge_reg   <= edge_u;
        w1c_reg    <= w1c_next;
        w2c_reg    <= w2c_next;
        w1e_reg    <= w1e_next;
        w2e_reg    <= w2e_next;
    end

    assign out_vld  = vld_reg;
    assign corner_q = corner_reg;
    assign edge_q   = edge_reg;
    assign w1c      = w1c_reg;
    assign w2c      = w2c_reg;
    assign w1e      = w1e_reg;
    assign w2e      = w2e_reg;

endmodule

### rtl/mhs_mac.sv
module mhs_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_vld,
    input  mhs_pkg::val_t                              corner_u [mhs_pkg::N_CORNER],
    input  mhs_pkg::val_t                              edge_u   [mhs_pkg::N_EDGE],
    input  logic signed [mhs_pkg::wt_w(FRAC_BITS)-1:0] w1c      [mhs_pkg::N_CORNER],
    input  logic signed [mhs_pkg::wt_w(FRAC_BITS)-1:0] w2c      [mhs_pkg::N_CORNER],
    input  logic signed [mhs_pkg::ew_w(FRAC_BITS)-1:0] w1e      [mhs_pkg::N_EDGE],
    input  logic signed [mhs_pkg::ew_w(FRAC_BITS)-1:0] w2e      [mhs_pkg::N_EDGE],
    output logic                                       out_vld,
    output logic signed [mhs_pkg::v_w(FRAC_BITS)-1:0]  v1,
    output logic signed [mhs_pkg::v_w(FRAC_BITS)-1:0]  v2
);

    localparam int CP_W  = mhs_pkg::cp_w(FRAC_BITS);
    localparam int EP_W  = mhs_pkg::ep_w(FRAC_BITS);
    localparam int SUM_W = mhs_pkg::sum_w(FRAC_BITS);
    localparam int V_W   = mhs_pkg::v_w(FRAC_BITS);

    // products
    logic                    p_vld_reg;
    logic signed [CP_W-1:0]  pc1_reg  [mhs_pkg::N_CORNER];
    logic signed [CP_W-1:0]  pc2_reg  [mhs_pkg::N_CORNER];
    logic signed [EP_W-1:0]  pe1_reg  [mhs_pkg::N_EDGE];
    logic signed [EP_W-1:0]  pe2_reg  [mhs_pkg::N_EDGE];
    logic signed [CP_W-1:0]  pc1_next [mhs_pkg::N_CORNER];
    logic signed [CP_W-1:0]  pc2_next [mhs_pkg::N_CORNER];
    logic signed [EP_W-1:0]  pe1_next [mhs_pkg::N_EDGE];
    logic signed [EP_W-1:0]  pe2_next [mhs_pkg::N_EDGE];

    // group sums
    logic                    s_vld_reg;
    logic signed [SUM_W-1:0] cs1_reg, es1_reg, cs2_reg, es2_reg;
    logic signed [SUM_W-1:0] cs1_next, es1_next, cs2_next, es2_next;

    // floored phase values
    logic                    v_vld_reg;
    logic signed [V_W-1:0]   v1_reg, v2_reg;
    logic signed [SUM_W-1:0] t1, t2;

    always_comb
    begin
        for (int i = 0; i < mhs_pkg::N_CORNER; i++)
        begin
            pc1_next[i] = corner_u[i] * w1c[i];
            pc2_next[i] = corner_u[i] * w2c[i];
        end
        // edge term is halved on its own, so it floors before the sum
        for (int i = 0; i < mhs_pkg::N_EDGE; i++)
        begin
            pe1_next[i] = (edge_u[i] * w1e[i]) >>> 1;
            pe2_next[i] = (edge_u[i] * w2e[i]) >>> 1;
        end
    end

    always_comb
    begin
        cs1_next = SUM_W'(pc1_reg[0]) + SUM_W'(pc1_reg[1])
                 + SUM_W'(pc1_reg[2]) + SUM_W'(pc1_reg[3]);
        cs2_next = SUM_W'(pc2_reg[0]) + SUM_W'(pc2_reg[1])
                 + SUM_W'(pc2_reg[2]) + SUM_W'(pc2_reg[3]);
        es1_next = SUM_W'(pe1_reg[0]) + SUM_W'(pe1_reg[1])
                 + SUM_W'(pe1_reg[2]) + SUM_W'(pe1_reg[3]);
        es2_next = SUM_W'(pe2_reg[0]) + SUM_W'(pe2_reg[1])
                 + SUM_W'(pe2_reg[2]) + SUM_W'(pe2_reg[3]);
    end

    assign t1 = cs1_reg + es1_reg;
    assign t2 = cs2_reg + es2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
            v_vld_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= in_vld;
            s_vld_reg <= p_vld_reg;
            v_vld_reg <= s_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pc1_reg <= pc1_next;
        pc2_reg <= pc2_next;
        pe1_reg <= pe1_next;
        pe2_reg <= pe2_next;
        cs1_reg <= cs1_next;
        cs2_reg <= cs2_next;
        es1_reg <= es1_next;
        es2_reg <= es2_next;
        // dropping the low bits floors to the value grid
        v1_reg  <= t1[SUM_W-1:FRAC_BITS];
        v2_reg  <= t2[SUM_W-1:FRAC_BITS];
    end

    assign out_vld = v_vld_reg;
    assign v1      = v1_reg;
    assign v2      = v2_reg;

endmodule

### rtl/mhs_scale.sv
module mhs_scale #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_vld,
    input  logic signed [mhs_pkg::v_w(FRAC_BITS)-1:0] v1,
    input  logic signed [mhs_pkg::v_w(FRAC_BITS)-1:0] v2,
    input  mhs_pkg::coef_t                            coef_one,
    input  mhs_pkg::coef_t                            coef_two,
    output logic                                      out_vld,
    output logic signed [mhs_pkg::RESP_W-1:0]         response
);

    localparam int V_W   = mhs_pkg::v_w(FRAC_BITS);
    localparam int HW    = mhs_pkg::CHALF_W;
    localparam int PP_W  = V_W + HW + 1;
    localparam int TOT_W = V_W + mhs_pkg::COEF_W + 1;
    localparam int SH_W  = TOT_W - FRAC_BITS;
    localparam int RW    = mhs_pkg::RESP_W;

    logic                    p_vld_reg, t_vld_reg, r_vld_reg;
    logic signed [PP_W-1:0]  p1l_reg, p1h_reg, p2l_reg, p2h_reg;
    logic signed [PP_W-1:0]  p1l_next, p1h_next, p2l_next, p2h_next;
    logic signed [TOT_W-1:0] hi_sum;
    logic signed [TOT_W-1:0] total_reg, total_next;
    logic signed [SH_W-1:0]  shifted;
    logic signed [RW-1:0]    resp_reg, resp_next;

    // coefficients split in halves keep each multiplier narrow
    always_comb
    begin
        p1l_next = v1 * $signed({1'b0, coef_one[HW-1:0]});
        p1h_next = v1 * $signed({1'b0, coef_one[mhs_pkg::COEF_W-1:HW]});
        p2l_next = v2 * $signed({1'b0, coef_two[HW-1:0]});
        p2h_next = v2 * $signed({1'b0, coef_two[mhs_pkg::COEF_W-1:HW]});
    end

    assign hi_sum     = TOT_W'(p1h_reg) + TOT_W'(p2h_reg);
    assign total_next = (hi_sum <<< HW) + TOT_W'(p1l_reg) + TOT_W'(p2l_reg);
    assign shifted    = total_reg[TOT_W-1:FRAC_BITS];

    always_comb
    begin
        if ((&shifted[SH_W-1:RW-1]) || !(|shifted[SH_W-1:RW-1]))
        begin
            resp_next = shifted[RW-1:0];
        end
        else if (shifted[SH_W-1])
        begin
            resp_next = mhs_pkg::RESP_MIN;
        end
        else
        begin
            resp_next = mhs_pkg::RESP_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            t_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= in_vld;
            t_vld_reg <= p_vld_reg;
            r_vld_reg <= t_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1l_reg   <= p1l_next;
        p1h_reg   <= p1h_next;
        p2l_reg   <= p2l_next;
        p2h_reg   <= p2h_next;
        total_reg <= total_next;
        resp_reg  <= resp_next;
    end

    assign out_vld  = r_vld_reg;
    assign response = resp_reg;

    // a saturated result must come from a sum that really left the range
    a_sat_min: assert property (@(posedge clk) disable iff (!rst_n)
        (t_vld_reg && (resp_next == mhs_pkg::RESP_MIN)) |-> shifted[SH_W-1])
        else $error("negative limit taken for a non-negative sum");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        (t_vld_reg && (resp_next == mhs_pkg::RESP_MAX)) |-> !shifted[SH_W-1])
        else $error("positive limit taken for a negative sum");

endmodule

### rtl/masked_heat_stencil_unit.sv
// channel   | signals                                        | beat taken when
// ----------+------------------------------------------------+------------------------
// item in   | start, busy, u_* (8 x s24), mask_* (4 x u17)   | start high, busy low
// result    | done, response (s32)                           | done high, one cycle
// config    | wr_en, wr_index, wr_data                       | wr_en high
//
// one item per cycle; each item passes through seven register stages:
// weights, products, group sums, flooring, coefficient partial products,
// final sum, shift and saturation
// busy stays low; results cannot be held off
// reset clears the valid bits and both coefficients
module masked_heat_stencil_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [mhs_pkg::VAL_W-1:0]      u_north_west,
    input  logic signed [mhs_pkg::VAL_W-1:0]      u_north,
    input  logic signed [mhs_pkg::VAL_W-1:0]      u_north_east,
    input  logic signed [mhs_pkg::VAL_W-1:0]      u_west,
    input  logic signed [mhs_pkg::VAL_W-1:0]      u_east,
    input  logic signed [mhs_pkg::VAL_W-1:0]      u_south_west,
    input  logic signed [mhs_pkg::VAL_W-1:0]      u_south,
    input  logic signed [mhs_pkg::VAL_W-1:0]      u_south_east,
    input  logic [mhs_pkg::MASK_W-1:0]            mask_nw,
    input  logic [mhs_pkg::MASK_W-1:0]            mask_ne,
    input  logic [mhs_pkg::MASK_W-1:0]            mask_sw,
    input  logic [mhs_pkg::MASK_W-1:0]            mask_se,
    output logic                                  done,
    output logic signed [mhs_pkg::RESP_W-1:0]     response,
    input  logic                                  wr_en,
    input  logic [mhs_pkg::REG_IDX_W-1:0]         wr_index,
    input  logic [mhs_pkg::COEF_W-1:0]            wr_data
);

    localparam int WT_W = mhs_pkg::wt_w(FRAC_BITS);
    localparam int EW_W = mhs_pkg::ew_w(FRAC_BITS);
    localparam int V_W  = mhs_pkg::v_w(FRAC_BITS);
    localparam int LAT  = 7;
    localparam int COEF_LAG = 3;

    mhs_pkg::coef_t         coef_one_reg, coef_two_reg;

    mhs_pkg::val_t          corner_u [mhs_pkg::N_CORNER];
    mhs_pkg::val_t          edge_u   [mhs_pkg::N_EDGE];
    mhs_pkg::mask_t         mask     [mhs_pkg::N_CORNER];

    logic                   w_vld;
    mhs_pkg::val_t          corner_q [mhs_pkg::N_CORNER];
    mhs_pkg::val_t          edge_q   [mhs_pkg::N_EDGE];
    logic signed [WT_W-1:0] w1c      [mhs_pkg::N_CORNER];
    logic signed [WT_W-1:0] w2c      [mhs_pkg::N_CORNER];
    logic signed [EW_W-1:0] w1e      [mhs_pkg::N_EDGE];
    logic signed [EW_W-1:0] w2e      [mhs_pkg::N_EDGE];

    logic                   m_vld;
    logic signed [V_W-1:0]  v1, v2;
    logic                   u_all_zero;

    assign corner_u = '{u_north_west, u_north_east, u_south_west, u_south_east};
    assign edge_u   = '{u_north, u_west, u_east, u_south};
    assign mask     = '{mask_nw, mask_ne, mask_sw, mask_se};

    // the pipeline takes a beat in every cycle
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_one_reg <= '0;
            coef_two_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                mhs_pkg::REG_COEF_ONE: coef_one_reg <= wr_data;
                mhs_pkg::REG_COEF_TWO: coef_two_reg <= wr_data;
                default: ;
            endcase
        end
    end

    mhs_weight #(
        .FRAC_BITS (FRAC_BITS)
    ) u_weight (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (start && !busy),
        .corner_u (corner_u),
        .edge_u   (edge_u),
        .mask     (mask),
        .out_vld  (w_vld),
        .corner_q (corner_q),
        .edge_q   (edge_q),
        .w1c      (w1c),
        .w2c      (w2c),
        .w1e      (w1e),
        .w2e      (w2e)
    );

    mhs_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (w_vld),
        .corner_u (corner_q),
        .edge_u   (edge_q),
        .w1c      (w1c),
        .w2c      (w2c),
        .w1e      (w1e),
        .w2e      (w2e),
        .out_vld  (m_vld),
        .v1       (v1),
        .v2       (v2)
    );

    mhs_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (m_vld),
        .v1       (v1),
        .v2       (v2),
        .coef_one (coef_one_reg),
        .coef_two (coef_two_reg),
        .out_vld  (done),
        .response (response)
    );

    assign u_all_zero = (u_north_west == '0) && (u_north == '0) && (u_north_east == '0)
                     && (u_west == '0) && (u_east == '0) && (u_south_west == '0)
                     && (u_south == '0) && (u_south_east == '0);

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result beat without an item accepted seven cycles earlier");

    a_zero_coef: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past((coef_one_reg == '0) && (coef_two_reg == '0), COEF_LAG))
        |-> (response == '0))
        else $error("non-zero response with both coefficients zero");

    a_zero_field: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(u_all_zero, LAT)) |-> (response == '0))
        else $error("non-zero response for an all-zero neighbourhood");

endmodule
